[hdl/pibc_pkg.sv]
// ----------------------------------------------------------------------------
// pibc_pkg: shared definitions for the particle integrate and box collide unit
// Default sizes, constants in Q16.16, register indexes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package pibc_pkg;

	localparam int MAX_BOXES_DEF      = 16;
	localparam int PARTICLE_SLOTS_DEF = 256;

	localparam int FX_ONE          = 65536;
	localparam int DRAG_MAX        = 64881;
	localparam int BOUNCE_K        = -19661;
	localparam int RESTITUTION_K   = 104858;
	localparam int SLOP_K          = 7;
	localparam int TIME_STEP_RESET = 1092;

	typedef enum logic [2:0] {
		REG_GRAVITY_X = 3'd0,
		REG_GRAVITY_Y = 3'd1,
		REG_DRAG_RATE = 3'd2,
		REG_TIME_STEP = 3'd3,
		REG_WIND_X    = 3'd4,
		REG_WIND_Y    = 3'd5,
		REG_BOX_COUNT = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		U_MUL  = 2'd0,
		U_DIV  = 2'd1,
		U_SQRT = 2'd2
	} uop_t;

	typedef enum logic [4:0] {
		S_IDLE, S_WAIT,
		S_DRAG, S_GX, S_GY, S_WX, S_WY, S_DX, S_DY, S_PX, S_PY, S_PYW,
		S_BOX, S_BRD, S_BCHK, S_SQY, S_RR, S_D2, S_LEN, S_ZV,
		S_NX, S_NY, S_PPX, S_PPY, S_VN1, S_VN2, S_K, S_KX, S_KY,
		S_NEXT, S_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
	} box_t;

	function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
		if (v > 58'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -58'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

[hdl/particle_integrate_box_collide_unit.sv]
// ----------------------------------------------------------------------------
// particle_integrate_box_collide_unit: Euler particle step with box collision
// Q16.16 particle update and circle push-out against a loaded box table.
// ----------------------------------------------------------------------------
// An input transaction with mode 0 loads one box slot without stalling.
// A transaction with mode 1 steps one particle. A particle whose life does
// not exceed the time step is dropped without stalling and gives no result.
// A survivor is worked by a sequencer around one shared iterative unit: a
// 36x36 multiplier built from one 36x19 multiplier, a radix-2 square root
// of 32 steps and a divider of 17 steps that share one subtractor. The
// integration runs first; then each box in use is tested, and a box near
// the circle adds more work on the unit, the most when they collide. The
// result is then loaded; only after that is the next particle taken.
// The box table is read through its registered read port, one box per pass.
// in_stall is high while a particle is worked. The result goes to an output
// register; when the receiver stalls, the next transaction is still taken
// and its result waits in the sequencer until the register frees.
// Reset clears the registers to their reset values, the survivor count and
// all handshakes. The box table is undefined until loaded.
// ----------------------------------------------------------------------------
module particle_integrate_box_collide_unit #(
	parameter int MAX_BOXES      = pibc_pkg::MAX_BOXES_DEF,
	parameter int PARTICLE_SLOTS = pibc_pkg::PARTICLE_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [3:0]         box_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [30:0]        life,
	input  logic [30:0]        radius,
	input  logic               last_particle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic [30:0]        remaining_life,
	output logic [30:0]        out_radius,
	output logic [7:0]         survivor_index
);

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int BW = $clog2(MAX_BOXES + 1);
	localparam int CW = $clog2(PARTICLE_SLOTS);

	pibc_pkg::state_t state_q, state_d, ret_q, ret_d;

	logic signed [31:0] gravity_x_q, gravity_y_q, wind_x_q, wind_y_q;
	logic [30:0]        drag_rate_q, time_step_q;
	logic [4:0]         box_count_q;

	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic [30:0]        life_q, r_q, len_q;
	logic               last_q;
	logic [16:0]        onem_q;
	logic signed [32:0] dx_q, dy_q;
	logic [62:0]        d2_q;
	logic signed [17:0] nx_q, ny_q;
	logic signed [34:0] vn_q;
	logic signed [35:0] k_q;
	logic [BW-1:0]      b_q;
	logic [CW-1:0]      surv_q;

	logic               out_valid_q;
	logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;
	logic [30:0]        olife_q, orad_q;
	logic [CW-1:0]      oidx_q;

	pibc_pkg::box_t     box_mem [MAX_BOXES];
	pibc_pkg::box_t     box_rd_q;

	// Shared iterative unit.
	logic               u_start;
	pibc_pkg::uop_t     u_op, uop_q;
	logic signed [35:0] u_a, u_b, a_q, bm_q;
	logic [63:0]        u_x;
	logic [30:0]        u_den, den_q;
	logic               ubusy_q, udone_q;
	logic [4:0]         ucnt_q;
	logic signed [71:0] acc_q;
	logic [63:0]        rad_q;
	logic [33:0]        rem_q;
	logic [31:0]        root_q;
	logic signed [18:0] mb;
	logic signed [54:0] pp;
	logic [33:0]        cmp_t, cmp_s, cmp_diff;
	logic               cmp_ge, u_last;

	logic               in_accept, alive, box_we, out_load;
	logic [AW+3:0]      widx;
	logic [9:0]         nb, bcur;
	logic signed [71:0] rsum;
	logic signed [55:0] fx;
	logic signed [57:0] fx58, vnsum;
	logic signed [35:0] dt36, pen36;
	logic signed [31:0] cx, cy;
	logic [32:0]        adx, ady;
	logic               miss;
	logic signed [33:0] lh, p2;
	logic [CW+7:0]      idx_ext;

	assign in_stall  = (state_q != pibc_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign alive     = life > time_step_q;
	assign widx      = {{AW{1'b0}}, box_index};
	assign box_we    = in_accept && !mode && ({5'b0, box_index} < 9'(MAX_BOXES));
	assign out_load  = (state_q == pibc_pkg::S_OUT) && (!out_valid_q || !out_stall);

	assign nb   = ({5'b0, box_count_q} < 10'(MAX_BOXES)) ? {5'b0, box_count_q} : 10'(MAX_BOXES);
	assign bcur = 10'(b_q);

	assign rsum  = acc_q + 72'sd32768;
	assign fx    = rsum[71:16];
	assign fx58  = 58'(fx);
	assign vnsum = 58'(vn_q) + fx58;
	assign dt36  = $signed({5'b0, time_step_q});
	assign pen36 = $signed({5'b0, r_q}) - $signed({5'b0, len_q})
		+ 36'(pibc_pkg::SLOP_K);

	assign cx = (px_q < box_rd_q.lo_x) ? box_rd_q.lo_x :
		((px_q > box_rd_q.hi_x) ? box_rd_q.hi_x : px_q);
	assign cy = (py_q < box_rd_q.lo_y) ? box_rd_q.lo_y :
		((py_q > box_rd_q.hi_y) ? box_rd_q.hi_y : py_q);
	assign adx  = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady  = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign miss = (adx >= {2'b0, r_q}) || (ady >= {2'b0, r_q});
	assign lh   = 34'(box_rd_q.lo_x) + 34'(box_rd_q.hi_x);
	assign p2   = {px_q[31], px_q, 1'b0};

	// Box table.
	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[widx[AW-1:0]] <= {pos_x, pos_y, vel_x, vel_y};
		end
		box_rd_q <= box_mem[b_q[AW-1:0]];
	end

	// Iterative unit datapath.
	assign mb = (ucnt_q == 5'd0) ? $signed({1'b0, bm_q[17:0]}) : $signed(bm_q[35:18]);
	assign pp = a_q * mb;

	always_comb begin
		if (uop_q == pibc_pkg::U_SQRT) begin
			cmp_t = {rem_q[31:0], rad_q[63:62]};
			cmp_s = {root_q, 2'b01};
		end else begin
			cmp_t = {rem_q[32:0], rad_q[63]};
			cmp_s = {3'b0, den_q};
		end
		cmp_ge   = cmp_t >= cmp_s;
		cmp_diff = cmp_t - cmp_s;
		case (uop_q)
			pibc_pkg::U_MUL:  u_last = (ucnt_q == 5'd1);
			pibc_pkg::U_DIV:  u_last = (ucnt_q == 5'd16);
			pibc_pkg::U_SQRT: u_last = (ucnt_q == 5'd31);
			default:          u_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ubusy_q <= 1'b0;
			udone_q <= 1'b0;
			ucnt_q  <= '0;
			uop_q   <= pibc_pkg::U_MUL;
		end else begin
			udone_q <= 1'b0;
			if (u_start) begin
				ubusy_q <= 1'b1;
				ucnt_q  <= '0;
				uop_q   <= u_op;
			end else if (ubusy_q) begin
				ucnt_q <= ucnt_q + 5'd1;
				if (u_last) begin
					ubusy_q <= 1'b0;
					udone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (u_start) begin
			a_q    <= u_a;
			bm_q   <= u_b;
			den_q  <= u_den;
			root_q <= '0;
			if (u_op == pibc_pkg::U_DIV) begin
				rem_q <= {3'b0, u_x[47:17]};
				rad_q <= {u_x[16:0], 47'b0};
			end else begin
				rem_q <= '0;
				rad_q <= u_x;
			end
		end else if (ubusy_q) begin
			case (uop_q)
				pibc_pkg::U_MUL: begin
					if (ucnt_q == 5'd0) begin
						acc_q <= 72'(pp);
					end else begin
						acc_q <= acc_q + (72'(pp) <<< 18);
					end
				end
				pibc_pkg::U_DIV: begin
					rem_q  <= cmp_ge ? cmp_diff : cmp_t;
					root_q <= {root_q[30:0], cmp_ge};
					rad_q  <= {rad_q[62:0], 1'b0};
				end
				pibc_pkg::U_SQRT: begin
					rem_q  <= cmp_ge ? cmp_diff : cmp_t;
					root_q <= {root_q[30:0], cmp_ge};
					rad_q  <= {rad_q[61:0], 2'b00};
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	// Sequencer: next state and unit issue.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		u_start = 1'b0;
		u_op    = pibc_pkg::U_MUL;
		u_a     = '0;
		u_b     = '0;
		u_x     = '0;
		u_den   = '0;
		case (state_q)
			pibc_pkg::S_IDLE: begin
				if (in_accept && mode && alive) begin
					state_d = pibc_pkg::S_DRAG;
				end
			end
			pibc_pkg::S_WAIT: begin
				if (udone_q) begin
					state_d = ret_q;
				end
			end
			pibc_pkg::S_DRAG: begin
				u_start = 1'b1; u_a = $signed({5'b0, drag_rate_q}); u_b = dt36;
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_GX;
			end
			pibc_pkg::S_GX: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(gravity_x_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_GY;
			end
			pibc_pkg::S_GY: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(gravity_y_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_WX;
			end
			pibc_pkg::S_WX: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(wind_x_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_WY;
			end
			pibc_pkg::S_WY: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(wind_y_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_DX;
			end
			pibc_pkg::S_DX: begin
				u_start = 1'b1; u_a = 36'(vx_q); u_b = $signed({19'b0, onem_q});
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_DY;
			end
			pibc_pkg::S_DY: begin
				u_start = 1'b1; u_a = 36'(vy_q); u_b = $signed({19'b0, onem_q});
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_PX;
			end
			pibc_pkg::S_PX: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(vx_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_PY;
			end
			pibc_pkg::S_PY: begin
				u_start = 1'b1; u_a = dt36; u_b = 36'(vy_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_PYW;
			end
			pibc_pkg::S_PYW: begin
				state_d = pibc_pkg::S_BOX;
			end
			pibc_pkg::S_BOX: begin
				state_d = (bcur >= nb) ? pibc_pkg::S_OUT : pibc_pkg::S_BRD;
			end
			pibc_pkg::S_BRD: begin
				state_d = pibc_pkg::S_BCHK;
			end
			pibc_pkg::S_BCHK: begin
				if (miss) begin
					state_d = pibc_pkg::S_NEXT;
				end else begin
					u_start = 1'b1; u_a = $signed({3'b0, adx}); u_b = $signed({3'b0, adx});
					state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_SQY;
				end
			end
			pibc_pkg::S_SQY: begin
				u_start = 1'b1; u_a = $signed({3'b0, ady}); u_b = $signed({3'b0, ady});
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_RR;
			end
			pibc_pkg::S_RR: begin
				u_start = 1'b1; u_a = $signed({5'b0, r_q}); u_b = $signed({5'b0, r_q});
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_D2;
			end
			pibc_pkg::S_D2: begin
				if (d2_q >= acc_q[62:0]) begin
					state_d = pibc_pkg::S_NEXT;
				end else begin
					u_start = 1'b1; u_op = pibc_pkg::U_SQRT; u_x = {1'b0, d2_q};
					state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_LEN;
				end
			end
			pibc_pkg::S_LEN: begin
				u_start = 1'b1;
				state_d = pibc_pkg::S_WAIT;
				if (root_q == 32'd0) begin
					u_a = 36'(vx_q); u_b = 36'(pibc_pkg::BOUNCE_K);
					ret_d = pibc_pkg::S_ZV;
				end else begin
					u_op = pibc_pkg::U_DIV; u_x = {33'b0, adx[30:0]} << 16;
					u_den = root_q[30:0];
					ret_d = pibc_pkg::S_NX;
				end
			end
			pibc_pkg::S_ZV: begin
				state_d = pibc_pkg::S_NEXT;
			end
			pibc_pkg::S_NX: begin
				u_start = 1'b1; u_op = pibc_pkg::U_DIV; u_x = {33'b0, ady[30:0]} << 16;
				u_den = len_q;
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_NY;
			end
			pibc_pkg::S_NY: begin
				u_start = 1'b1; u_a = 36'(nx_q); u_b = pen36;
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_PPX;
			end
			pibc_pkg::S_PPX: begin
				u_start = 1'b1; u_a = 36'(ny_q); u_b = pen36;
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_PPY;
			end
			pibc_pkg::S_PPY: begin
				u_start = 1'b1; u_a = 36'(vx_q); u_b = 36'(nx_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_VN1;
			end
			pibc_pkg::S_VN1: begin
				u_start = 1'b1; u_a = 36'(vy_q); u_b = 36'(ny_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_VN2;
			end
			pibc_pkg::S_VN2: begin
				if (vnsum < 58'sd0) begin
					u_start = 1'b1; u_a = 36'(pibc_pkg::RESTITUTION_K); u_b = vnsum[35:0];
					state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_K;
				end else begin
					state_d = pibc_pkg::S_NEXT;
				end
			end
			pibc_pkg::S_K: begin
				u_start = 1'b1; u_a = fx[35:0]; u_b = 36'(nx_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_KX;
			end
			pibc_pkg::S_KX: begin
				u_start = 1'b1; u_a = k_q; u_b = 36'(ny_q);
				state_d = pibc_pkg::S_WAIT; ret_d = pibc_pkg::S_KY;
			end
			pibc_pkg::S_KY: begin
				state_d = pibc_pkg::S_NEXT;
			end
			pibc_pkg::S_NEXT: begin
				state_d = pibc_pkg::S_BOX;
			end
			pibc_pkg::S_OUT: begin
				if (out_load) begin
					state_d = pibc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pibc_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pibc_pkg::S_IDLE;
			ret_q       <= pibc_pkg::S_IDLE;
			b_q         <= '0;
			surv_q      <= '0;
			out_valid_q <= 1'b0;
			gravity_x_q <= '0;
			gravity_y_q <= '0;
			drag_rate_q <= '0;
			time_step_q <= 31'(pibc_pkg::TIME_STEP_RESET);
			wind_x_q    <= '0;
			wind_y_q    <= '0;
			box_count_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == pibc_pkg::S_PYW) begin
				b_q <= '0;
			end else if (state_q == pibc_pkg::S_NEXT) begin
				b_q <= b_q + 1'b1;
			end
			if (in_accept && mode && !alive && last_particle) begin
				surv_q <= '0;
			end else if (out_load) begin
				if (last_q || (surv_q == CW'(PARTICLE_SLOTS - 1))) begin
					surv_q <= '0;
				end else begin
					surv_q <= surv_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (pibc_pkg::cfg_reg_t'(cfg_index))
					pibc_pkg::REG_GRAVITY_X: gravity_x_q <= cfg_data;
					pibc_pkg::REG_GRAVITY_Y: gravity_y_q <= cfg_data;
					pibc_pkg::REG_DRAG_RATE: drag_rate_q <= cfg_data[30:0];
					pibc_pkg::REG_TIME_STEP: time_step_q <= cfg_data[30:0];
					pibc_pkg::REG_WIND_X:    wind_x_q    <= cfg_data;
					pibc_pkg::REG_WIND_Y:    wind_y_q    <= cfg_data;
					pibc_pkg::REG_BOX_COUNT: box_count_q <= cfg_data[4:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Particle datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			pibc_pkg::S_IDLE: begin
				if (in_accept) begin
					px_q   <= pos_x;
					py_q   <= pos_y;
					vx_q   <= vel_x;
					vy_q   <= vel_y;
					life_q <= life - time_step_q;
					r_q    <= radius;
					last_q <= last_particle;
				end
			end
			pibc_pkg::S_GX: begin
				onem_q <= 17'(pibc_pkg::FX_ONE) - ((fx > 56'(pibc_pkg::DRAG_MAX)) ?
					17'(pibc_pkg::DRAG_MAX) : {1'b0, fx[15:0]});
			end
			pibc_pkg::S_GY:  vx_q <= pibc_pkg::sat32(58'(vx_q) + fx58);
			pibc_pkg::S_WX:  vy_q <= pibc_pkg::sat32(58'(vy_q) + fx58);
			pibc_pkg::S_WY:  vx_q <= pibc_pkg::sat32(58'(vx_q) + fx58);
			pibc_pkg::S_DX:  vy_q <= pibc_pkg::sat32(58'(vy_q) + fx58);
			pibc_pkg::S_DY:  vx_q <= pibc_pkg::sat32(fx58);
			pibc_pkg::S_PX:  vy_q <= pibc_pkg::sat32(fx58);
			pibc_pkg::S_PY:  px_q <= pibc_pkg::sat32(58'(px_q) + fx58);
			pibc_pkg::S_PYW: py_q <= pibc_pkg::sat32(58'(py_q) + fx58);
			pibc_pkg::S_BRD: begin
				dx_q <= 33'(px_q) - 33'(cx);
				dy_q <= 33'(py_q) - 33'(cy);
			end
			pibc_pkg::S_SQY: d2_q <= acc_q[62:0];
			pibc_pkg::S_RR:  d2_q <= d2_q + acc_q[62:0];
			pibc_pkg::S_LEN: begin
				len_q <= root_q[30:0];
				if (root_q == 32'd0) begin
					if (lh > p2) begin
						px_q <= pibc_pkg::sat32(58'(box_rd_q.lo_x) - 58'($signed({1'b0, r_q})));
					end else begin
						px_q <= pibc_pkg::sat32(58'(box_rd_q.hi_x) + 58'($signed({1'b0, r_q})));
					end
				end
			end
			pibc_pkg::S_ZV:  vx_q <= fx[31:0];
			pibc_pkg::S_NX: begin
				nx_q <= dx_q[32] ? -$signed({1'b0, root_q[16:0]}) : $signed({1'b0, root_q[16:0]});
			end
			pibc_pkg::S_NY: begin
				ny_q <= dy_q[32] ? -$signed({1'b0, root_q[16:0]}) : $signed({1'b0, root_q[16:0]});
			end
			pibc_pkg::S_PPX: px_q <= pibc_pkg::sat32(58'(px_q) + fx58);
			pibc_pkg::S_PPY: py_q <= pibc_pkg::sat32(58'(py_q) + fx58);
			pibc_pkg::S_VN1: vn_q <= fx[34:0];
			pibc_pkg::S_K:   k_q  <= fx[35:0];
			pibc_pkg::S_KX:  vx_q <= pibc_pkg::sat32(58'(vx_q) - fx58);
			pibc_pkg::S_KY:  vy_q <= pibc_pkg::sat32(58'(vy_q) - fx58);
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			opx_q   <= px_q;
			opy_q   <= py_q;
			ovx_q   <= vx_q;
			ovy_q   <= vy_q;
			olife_q <= life_q;
			orad_q  <= r_q;
			oidx_q  <= surv_q;
		end
	end

	assign idx_ext        = {8'b0, oidx_q};
	assign out_valid      = out_valid_q;
	assign new_pos_x      = opx_q;
	assign new_pos_y      = opy_q;
	assign new_vel_x      = ovx_q;
	assign new_vel_y      = ovy_q;
	assign remaining_life = olife_q;
	assign out_radius     = orad_q;
	assign survivor_index = idx_ext[7:0];

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		u_start |-> !ubusy_q)
		else $error("shared unit started while busy");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		udone_q |-> state_q == pibc_pkg::S_WAIT)
		else $error("unit result not awaited");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == pibc_pkg::S_OUT)
		else $error("result shown without sequencer");

	a_live_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && mode && alive) |=> state_q == pibc_pkg::S_DRAG)
		else $error("live particle not started");

endmodule
